[hdl/trs_pkg.sv]
package trs_pkg;

    localparam int STATION_ENTRIES_DEF = 32;
    localparam int ROB_DEPTH_DEF       = 32;

    localparam int ACTION_W = 3;
    localparam int OP_W     = 7;
    localparam int VALUE_W  = 32;
    localparam int SREG_W   = 6;
    localparam int TAG_W    = 5;

    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 1;

    // All-ones in a signed 6-bit field: no register, or no pending tag.
    localparam logic signed [SREG_W-1:0] SREG_NONE = -6'sd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TABLE     = 3'd0,
        ACT_DISPATCH  = 3'd1,
        ACT_ALU       = 3'd2,
        ACT_LOAD      = 3'd3,
        ACT_CYCLE_END = 3'd4,
        ACT_FLUSH     = 3'd5
    } action_t;

    // Input tdata layout; the last member sits in the lowest bits.
    typedef struct packed {
        logic        [TAG_W-1:0]   dest_tag;
        logic signed [SREG_W-1:0]  dep_tag;
        logic signed [SREG_W-1:0]  dep_reg;
        logic signed [SREG_W-1:0]  reg_b;
        logic signed [SREG_W-1:0]  reg_a;
        logic signed [SREG_W-1:0]  tag_b;
        logic signed [SREG_W-1:0]  tag_a;
        logic signed [VALUE_W-1:0] value_b;
        logic signed [VALUE_W-1:0] value_a;
        logic        [OP_W-1:0]    op_code;
    } in_item_t;

    // Result tdata layout, zero filled to whole bytes.
    typedef struct packed {
        logic        [3:0]         pad;
        logic signed [VALUE_W-1:0] issue_b;
        logic signed [VALUE_W-1:0] issue_a;
        logic        [OP_W-1:0]    issue_op;
        logic        [TAG_W-1:0]   issue_tag;
    } out_item_t;

endpackage

[hdl/tomasulo_reservation_station_core.sv]
// A cycle-end transaction is held in the input register, and its issue result is then registered
// into the result register that drives m_tvalid, m_tdata and m_tuser.
// Throughput: one transaction per cycle; all tag compares run in parallel in one stage, and
// the stage stalls only while a cycle-end transaction finds an earlier result waiting for m_tready.
// Reset (aresetn low, synchronous): clears station occupancy, the snapshot fill count and
// tag marks, and both stage valids. Entry payload and snapshot values are not reset.
module tomasulo_reservation_station_core #(
    parameter int STATION_ENTRIES = trs_pkg::STATION_ENTRIES_DEF,
    parameter int ROB_DEPTH       = trs_pkg::ROB_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op_code, value_a, value_b, tag_a, tag_b, reg_a, reg_b, dep_reg, dep_tag, dest_tag
    input  logic [trs_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [trs_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // issue_tag, issue_op, issue_a, issue_b, zero fill
    output logic [trs_pkg::M_TDATA_W-1:0]  m_tdata,
    // issue_valid
    output logic [trs_pkg::M_TUSER_W-1:0]  m_tuser
);
    import trs_pkg::*;

    localparam int IDX_W  = $clog2(STATION_ENTRIES);
    localparam int CNT_W  = $clog2(ROB_DEPTH + 1);
    localparam int SNAP_N = 2 ** TAG_W;

    // Input stage.
    logic                  stg_vld_reg;
    action_t               stg_act_reg;
    in_item_t              stg_item_reg;
    logic [VALUE_W-1:0]    snap_rd_a_reg;
    logic [VALUE_W-1:0]    snap_rd_b_reg;

    // Snapshot, indexed by reorder-buffer tag; a mark means the tag was entered this cycle.
    logic [VALUE_W-1:0]    snap_mem [SNAP_N];
    logic [SNAP_N-1:0]     snap_vld_reg;
    logic [CNT_W-1:0]      snap_cnt_reg;

    // Station entries.
    logic [STATION_ENTRIES-1:0] busy_reg;
    logic [STATION_ENTRIES-1:0] ent_rdy_a_reg;
    logic [STATION_ENTRIES-1:0] ent_rdy_b_reg;
    logic [TAG_W-1:0]           ent_tag_a_reg [STATION_ENTRIES];
    logic [TAG_W-1:0]           ent_tag_b_reg [STATION_ENTRIES];
    logic [VALUE_W-1:0]         ent_a_reg     [STATION_ENTRIES];
    logic [VALUE_W-1:0]         ent_b_reg     [STATION_ENTRIES];
    logic [OP_W-1:0]            ent_op_reg    [STATION_ENTRIES];
    logic [TAG_W-1:0]           ent_dest_reg  [STATION_ENTRIES];

    // Result register.
    logic                  m_tvalid_reg;
    out_item_t             m_tdata_reg;
    logic                  m_tuser_reg;

    in_item_t              in_item;
    logic                  s_acc;
    logic                  stg_fire;
    logic [TAG_W-1:0]      stg_tag_idx;
    logic                  snap_we;
    logic                  snap_new;

    logic                  hit_a, hit_b;
    logic [VALUE_W-1:0]    new_a, new_b;
    logic                  new_rdy_a, new_rdy_b;
    logic [TAG_W-1:0]      new_tag_a, new_tag_b;

    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic                  iss_found;
    logic [IDX_W-1:0]      iss_idx;
    logic                  is_wake;
    out_item_t             iss_item;

    assign in_item = in_item_t'(s_tdata);

    assign stg_fire = stg_vld_reg &&
                      (stg_act_reg != ACT_CYCLE_END || !m_tvalid_reg || m_tready);
    assign s_tready = !stg_vld_reg || stg_fire;
    assign s_acc    = s_tvalid && s_tready;

    assign stg_tag_idx = stg_item_reg.tag_a[TAG_W-1:0];
    assign snap_we  = stg_fire && stg_act_reg == ACT_TABLE && !stg_item_reg.tag_a[SREG_W-1] &&
                      snap_cnt_reg < CNT_W'(ROB_DEPTH);
    // The first table transaction for a tag in a cycle is the one a lookup finds.
    assign snap_new = snap_we && !snap_vld_reg[stg_tag_idx];
    assign is_wake  = (stg_act_reg == ACT_ALU || stg_act_reg == ACT_LOAD) &&
                      !stg_item_reg.tag_a[SREG_W-1];

    // Source resolution for a dispatch.
    always_comb begin
        hit_a     = !stg_item_reg.tag_a[SREG_W-1] &&
                    snap_vld_reg[stg_item_reg.tag_a[TAG_W-1:0]];
        hit_b     = !stg_item_reg.tag_b[SREG_W-1] &&
                    snap_vld_reg[stg_item_reg.tag_b[TAG_W-1:0]];
        new_a     = hit_a ? snap_rd_a_reg : stg_item_reg.value_a;
        new_b     = hit_b ? snap_rd_b_reg : stg_item_reg.value_b;
        new_rdy_a = stg_item_reg.tag_a[SREG_W-1] || hit_a;
        new_rdy_b = stg_item_reg.tag_b[SREG_W-1] || hit_b;
        new_tag_a = stg_item_reg.tag_a[TAG_W-1:0];
        new_tag_b = stg_item_reg.tag_b[TAG_W-1:0];
        // The newest writer of a source register overrides whatever the snapshot gave.
        if (stg_item_reg.reg_a != SREG_NONE && stg_item_reg.reg_a == stg_item_reg.dep_reg) begin
            new_rdy_a = stg_item_reg.dep_tag[SREG_W-1];
            new_tag_a = stg_item_reg.dep_tag[TAG_W-1:0];
        end
        if (stg_item_reg.reg_b != SREG_NONE && stg_item_reg.reg_b == stg_item_reg.dep_reg) begin
            new_rdy_b = stg_item_reg.dep_tag[SREG_W-1];
            new_tag_b = stg_item_reg.dep_tag[TAG_W-1:0];
        end
    end

    // Lowest free entry and lowest ready entry.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        iss_found  = 1'b0;
        iss_idx    = '0;
        for (int i = STATION_ENTRIES - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
            if (busy_reg[i] && ent_rdy_a_reg[i] && ent_rdy_b_reg[i]) begin
                iss_found = 1'b1;
                iss_idx   = IDX_W'(i);
            end
        end
    end

    // Issue payload; all fields stay zero when nothing is ready.
    always_comb begin
        iss_item = '0;
        if (iss_found) begin
            iss_item.issue_tag = ent_dest_reg[iss_idx];
            iss_item.issue_op  = ent_op_reg[iss_idx];
            iss_item.issue_a   = ent_a_reg[iss_idx];
            iss_item.issue_b   = ent_b_reg[iss_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= 1'b0;
        end else if (s_tready) begin
            stg_vld_reg <= s_tvalid;
        end
        if (s_acc) begin
            stg_act_reg  <= action_t'(s_tuser);
            stg_item_reg <= in_item;
        end
    end

    // Snapshot values; a table write leaving the stage is forwarded to the read beside it.
    always_ff @(posedge aclk) begin
        if (snap_new) begin
            snap_mem[stg_tag_idx] <= stg_item_reg.value_a;
        end
        if (s_acc) begin
            if (snap_new && stg_tag_idx == in_item.tag_a[TAG_W-1:0]) begin
                snap_rd_a_reg <= stg_item_reg.value_a;
            end else begin
                snap_rd_a_reg <= snap_mem[in_item.tag_a[TAG_W-1:0]];
            end
            if (snap_new && stg_tag_idx == in_item.tag_b[TAG_W-1:0]) begin
                snap_rd_b_reg <= stg_item_reg.value_a;
            end else begin
                snap_rd_b_reg <= snap_mem[in_item.tag_b[TAG_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_vld_reg <= '0;
            snap_cnt_reg <= '0;
        end else if (stg_fire) begin
            case (stg_act_reg)
                ACT_TABLE: begin
                    if (snap_we) begin
                        snap_vld_reg[stg_tag_idx] <= 1'b1;
                        snap_cnt_reg              <= snap_cnt_reg + CNT_W'(1);
                    end
                end
                ACT_CYCLE_END: begin
                    snap_vld_reg <= '0;
                    snap_cnt_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else if (stg_fire) begin
            case (stg_act_reg)
                ACT_DISPATCH: begin
                    if (free_found) begin
                        busy_reg[free_idx] <= 1'b1;
                    end
                end
                ACT_CYCLE_END: begin
                    if (iss_found) begin
                        busy_reg[iss_idx] <= 1'b0;
                    end
                end
                ACT_FLUSH: begin
                    busy_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Entry payload: dispatch writes one entry, a broadcast wakes every matching source.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < STATION_ENTRIES; i++) begin
            if (stg_fire && stg_act_reg == ACT_DISPATCH && free_found &&
                free_idx == IDX_W'(i)) begin
                ent_op_reg[i]    <= stg_item_reg.op_code;
                ent_a_reg[i]     <= new_a;
                ent_b_reg[i]     <= new_b;
                ent_rdy_a_reg[i] <= new_rdy_a;
                ent_rdy_b_reg[i] <= new_rdy_b;
                ent_tag_a_reg[i] <= new_tag_a;
                ent_tag_b_reg[i] <= new_tag_b;
                ent_dest_reg[i]  <= stg_item_reg.dest_tag;
            end else if (stg_fire && is_wake && busy_reg[i]) begin
                if (!ent_rdy_a_reg[i] && ent_tag_a_reg[i] == stg_tag_idx) begin
                    ent_rdy_a_reg[i] <= 1'b1;
                    ent_a_reg[i]     <= stg_item_reg.value_a;
                end
                if (!ent_rdy_b_reg[i] && ent_tag_b_reg[i] == stg_tag_idx) begin
                    ent_rdy_b_reg[i] <= 1'b1;
                    ent_b_reg[i]     <= stg_item_reg.value_a;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (stg_fire && stg_act_reg == ACT_CYCLE_END) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (stg_fire && stg_act_reg == ACT_CYCLE_END) begin
            m_tuser_reg <= iss_found;
            m_tdata_reg <= iss_item;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hdl/trs_checker.sv]
module trs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [trs_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [trs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [trs_pkg::M_TUSER_W-1:0] m_tuser
);
    import trs_pkg::*;

    // A stalled result transaction keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An empty issue carries all-zero fields.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty issue with nonzero fields");

    // A fresh result follows a cycle-end transaction accepted on the input channel.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == ACT_CYCLE_END, 2))
        else $error("result without a cycle-end transaction");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tomasulo_reservation_station_core trs_checker u_trs_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import trs_pkg::*;

    localparam int RS_SLOTS       = STATION_ENTRIES_DEF;
    localparam int SNAP_SLOTS     = ROB_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic      valid;
        out_item_t data;
    } issue_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // Shadow of the station and of the per-cycle table of known values.
    logic                   slot_busy   [RS_SLOTS] = '{default: 1'b0};
    logic [OP_W-1:0]        slot_op     [RS_SLOTS];
    logic [VALUE_W-1:0]     slot_val_a  [RS_SLOTS];
    logic [VALUE_W-1:0]     slot_val_b  [RS_SLOTS];
    logic signed [5:0]      slot_pend_a [RS_SLOTS];
    logic signed [5:0]      slot_pend_b [RS_SLOTS];
    logic [TAG_W-1:0]       slot_dest   [RS_SLOTS];
    logic signed [5:0]      known_tag   [SNAP_SLOTS];
    logic [VALUE_W-1:0]     known_value [SNAP_SLOTS];
    int                     known_count = 0;

    issue_t                 pending_issues[$];
    logic                   quiet_stretch = 1'b0;
    int                     error_count   = 0;
    int                     stall_cycles  = 0;
    int                     items_sent    = 0;
    int                     n_cycle_ends  = 0;
    int                     n_issued      = 0;
    int                     n_dropped     = 0;
    int                     n_snap_ignored = 0;
    int                     n_flushes     = 0;

    tomasulo_reservation_station_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 24);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic signed [5:0] norm_tag(input logic signed [5:0] t);
        return t[5] ? SREG_NONE : t;
    endfunction

    // Look a pending tag up in this cycle's table; the first hit wins.
    function automatic void resolve_operand(inout logic signed [5:0] pend,
                                            inout logic [VALUE_W-1:0] val);
        if (pend[5]) return;
        for (int i = 0; i < known_count; i++) begin
            if (known_tag[i] == pend) begin
                pend = SREG_NONE;
                val  = known_value[i];
                return;
            end
        end
    endfunction

    task automatic predict_item(input logic [2:0] act, input in_item_t it);
        logic signed [5:0]  wa;
        logic signed [5:0]  wb;
        logic [VALUE_W-1:0] va;
        logic [VALUE_W-1:0] vb;
        logic               placed;
        issue_t             res;
        case (act)
            ACT_TABLE: begin
                if (!it.tag_a[5] && known_count < SNAP_SLOTS) begin
                    known_tag[known_count]   = it.tag_a;
                    known_value[known_count] = it.value_a;
                    known_count++;
                end else begin
                    n_snap_ignored++;
                end
            end
            ACT_DISPATCH: begin
                wa = norm_tag(it.tag_a);
                wb = norm_tag(it.tag_b);
                va = it.value_a;
                vb = it.value_b;
                resolve_operand(wa, va);
                resolve_operand(wb, vb);
                // The newest writer overrides even a tag the table already resolved.
                if (it.reg_a != SREG_NONE && it.reg_a == it.dep_reg) wa = norm_tag(it.dep_tag);
                if (it.reg_b != SREG_NONE && it.reg_b == it.dep_reg) wb = norm_tag(it.dep_tag);
                placed = 1'b0;
                for (int i = 0; i < RS_SLOTS && !placed; i++) begin
                    if (!slot_busy[i]) begin
                        slot_busy[i]   = 1'b1;
                        slot_op[i]     = it.op_code;
                        slot_val_a[i]  = va;
                        slot_val_b[i]  = vb;
                        slot_pend_a[i] = wa;
                        slot_pend_b[i] = wb;
                        slot_dest[i]   = it.dest_tag;
                        placed = 1'b1;
                    end
                end
                if (!placed) n_dropped++;
            end
            ACT_ALU, ACT_LOAD: begin
                if (!it.tag_a[5]) begin
                    for (int i = 0; i < RS_SLOTS; i++) begin
                        if (slot_busy[i] && slot_pend_a[i] == it.tag_a) begin
                            slot_pend_a[i] = SREG_NONE;
                            slot_val_a[i]  = it.value_a;
                        end
                        if (slot_busy[i] && slot_pend_b[i] == it.tag_a) begin
                            slot_pend_b[i] = SREG_NONE;
                            slot_val_b[i]  = it.value_a;
                        end
                    end
                end
            end
            ACT_CYCLE_END: begin
                res.valid = 1'b0;
                res.data  = '0;
                for (int i = 0; i < RS_SLOTS && !res.valid; i++) begin
                    if (slot_busy[i] && slot_pend_a[i][5] && slot_pend_b[i][5]) begin
                        res.valid          = 1'b1;
                        res.data.issue_tag = slot_dest[i];
                        res.data.issue_op  = slot_op[i];
                        res.data.issue_a   = slot_val_a[i];
                        res.data.issue_b   = slot_val_b[i];
                        slot_busy[i]       = 1'b0;
                    end
                end
                pending_issues.push_back(res);
                known_count = 0;
                n_cycle_ends++;
                if (res.valid) n_issued++;
            end
            ACT_FLUSH: begin
                for (int i = 0; i < RS_SLOTS; i++) slot_busy[i] = 1'b0;
                n_flushes++;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [2:0] act, input in_item_t it);
        while (!quiet_stretch && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= it;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(act, it);
        items_sent++;
    endtask

    always @(posedge aclk) begin
        issue_t    exp;
        out_item_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_issues.size() == 0) begin
                report_mismatch("issue transaction with nothing expected");
            end else begin
                exp = pending_issues.pop_front();
                if (m_tuser[0] !== exp.valid)
                    report_mismatch($sformatf("issue_valid got %b want %b", m_tuser[0], exp.valid));
                if (got.issue_tag !== exp.data.issue_tag)
                    report_mismatch($sformatf("issue_tag got %0d want %0d",
                                              got.issue_tag, exp.data.issue_tag));
                if (got.issue_op !== exp.data.issue_op)
                    report_mismatch($sformatf("issue_op got %0d want %0d",
                                              got.issue_op, exp.data.issue_op));
                if (got.issue_a !== exp.data.issue_a)
                    report_mismatch($sformatf("issue_a got %h want %h",
                                              got.issue_a, exp.data.issue_a));
                if (got.issue_b !== exp.data.issue_b)
                    report_mismatch($sformatf("issue_b got %h want %h",
                                              got.issue_b, exp.data.issue_b));
                if (got.pad !== 4'd0)
                    report_mismatch($sformatf("zero fill got %h", got.pad));
            end
        end
    end

    // Ends the run when neither channel has moved a transaction for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d issues outstanding", pending_issues.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic in_item_t quiet_item();
        in_item_t it;
        it         = '0;
        it.tag_a   = SREG_NONE;
        it.tag_b   = SREG_NONE;
        it.reg_a   = SREG_NONE;
        it.reg_b   = SREG_NONE;
        it.dep_reg = SREG_NONE;
        it.dep_tag = SREG_NONE;
        return it;
    endfunction

    function automatic in_item_t rand_item();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[S_TDATA_W-1:0];
    endfunction

    // Mostly a tag some busy slot is still waiting on, so broadcasts and table entries hit.
    function automatic logic signed [5:0] pick_pending_tag();
        logic signed [5:0] waiting[$];
        for (int i = 0; i < RS_SLOTS; i++) begin
            if (slot_busy[i] && !slot_pend_a[i][5]) waiting.push_back(slot_pend_a[i]);
            if (slot_busy[i] && !slot_pend_b[i][5]) waiting.push_back(slot_pend_b[i]);
        end
        if (waiting.size() == 0 || $urandom_range(4) == 0) return 6'($urandom_range(31));
        return waiting[$urandom_range(waiting.size() - 1)];
    endfunction

    function automatic logic signed [5:0] pick_source_tag();
        case ($urandom_range(9))
            0, 1, 2, 3: return SREG_NONE;
            4:          return 6'($urandom_range(63));
            5, 6:       return (known_count > 0) ? known_tag[$urandom_range(known_count - 1)]
                                                 : 6'($urandom_range(31));
            default:    return 6'($urandom_range(31));
        endcase
    endfunction

    function automatic in_item_t make_dispatch();
        in_item_t it;
        it       = rand_item();
        it.tag_a = pick_source_tag();
        it.tag_b = pick_source_tag();
        if ($urandom_range(1)) it.dep_reg = $urandom_range(1) ? it.reg_a : it.reg_b;
        return it;
    endfunction

    function automatic in_item_t make_tagged(input bit pending_bias);
        in_item_t it;
        it       = rand_item();
        it.tag_a = (pending_bias && $urandom_range(7) != 0) ? pick_pending_tag()
                                                            : 6'($urandom_range(63));
        return it;
    endfunction

    // One core cycle: table entries, dispatches and broadcasts, cycle end, maybe a flush.
    task automatic play_core_cycle(input bit heavy);
        int n_table;
        int n_steps;
        n_table = (heavy && $urandom_range(7) == 0) ? $urandom_range(30, 40)
                                                    : $urandom_range(0, 3);
        repeat (n_table) send_item(ACT_TABLE, make_tagged(1'b1));
        n_steps = heavy ? $urandom_range(2, 6) : $urandom_range(0, 4);
        repeat (n_steps) begin
            case ($urandom_range(9))
                0:       send_item(3'($urandom_range(7)), rand_item());
                1, 2:    send_item(ACT_ALU, make_tagged(1'b1));
                3:       send_item(ACT_LOAD, make_tagged(1'b1));
                4:       send_item(ACT_TABLE, make_tagged(1'b1));
                default: send_item(ACT_DISPATCH, make_dispatch());
            endcase
        end
        send_item(ACT_CYCLE_END, rand_item());
        if ($urandom_range(99) < (heavy ? 1 : 4)) send_item(ACT_FLUSH, rand_item());
    endtask

    task automatic test_directed_cases();
        in_item_t it;
        it = quiet_item();
        send_item(ACT_CYCLE_END, it);
        it.tag_a = 6'sd3;   it.value_a = 32'h1111_1111; send_item(ACT_TABLE, it);
        it.tag_a = -6'sd5;  it.value_a = 32'hdead_beef; send_item(ACT_TABLE, it);
        it.tag_a = 6'sd3;   it.value_a = 32'h2222_2222; send_item(ACT_TABLE, it);
        it.tag_a = 6'sd31;  it.value_a = 32'hffff_ffff; send_item(ACT_TABLE, it);
        // Source a resolves from the table; source b is ready at the extreme value.
        it = quiet_item();
        it.op_code = 7'd127; it.tag_a = 6'sd3; it.value_b = 32'h7fff_ffff; it.dest_tag = 5'd31;
        send_item(ACT_DISPATCH, it);
        // Most negative tag counts as ready; the newest writer makes source a wait on 9.
        it = quiet_item();
        it.tag_a = -6'sd32; it.value_a = 32'h8000_0000; it.tag_b = 6'sd7;
        it.reg_a = 6'sd5; it.dep_reg = 6'sd5; it.dep_tag = 6'sd9;
        send_item(ACT_DISPATCH, it);
        // A negative writer tag overrides both sources to ready.
        it = quiet_item();
        it.op_code = 7'h55; it.tag_a = 6'sd31; it.tag_b = 6'sd20; it.value_b = 32'h0bad_cafe;
        it.reg_a = 6'sd31; it.reg_b = 6'sd31; it.dep_reg = 6'sd31; it.dep_tag = -6'sd3;
        it.dest_tag = 5'd21;
        send_item(ACT_DISPATCH, it);
        // A resolved source is still replaced by the newest writer's tag.
        it = quiet_item();
        it.op_code = 7'h2a; it.tag_a = 6'sd3; it.reg_a = 6'sd2; it.dep_reg = 6'sd2;
        it.dep_tag = 6'sd12; it.reg_b = -6'sd5; it.dest_tag = 5'd10;
        send_item(ACT_DISPATCH, it);
        send_item(ACT_CYCLE_END, rand_item());
        send_item(ACT_CYCLE_END, rand_item());
        it = quiet_item();
        it.tag_a = 6'sd7;  it.value_a = 32'h0000_0007; send_item(ACT_ALU, it);
        it.tag_a = 6'sd9;  it.value_a = 32'hffff_fff9; send_item(ACT_LOAD, it);
        it.tag_a = -6'sd1; it.value_a = 32'h1234_5678; send_item(ACT_ALU, it);
        it.tag_a = 6'sd12; it.value_a = 32'h8000_000c; send_item(ACT_LOAD, it);
        send_item(3'd6, rand_item());
        send_item(3'd7, rand_item());
        send_item(ACT_CYCLE_END, rand_item());
        send_item(ACT_CYCLE_END, rand_item());
        send_item(ACT_CYCLE_END, rand_item());
        // The table was cleared at cycle end, so tag 3 now stays pending until the flush.
        it = quiet_item();
        it.tag_a = 6'sd3; it.dest_tag = 5'd4;
        send_item(ACT_DISPATCH, it);
        send_item(ACT_FLUSH, rand_item());
        send_item(ACT_CYCLE_END, rand_item());
    endtask

    task automatic test_mixed_traffic(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) play_core_cycle(1'b0);
    endtask

    task automatic test_back_to_back(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        quiet_stretch <= 1'b1;
        while (items_sent < stop_at) play_core_cycle(1'b0);
        quiet_stretch <= 1'b0;
    endtask

    // Dispatch faster than issue and send table bursts, so both structures overflow.
    task automatic test_full_structures(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) play_core_cycle(1'b1);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_mixed_traffic(800);
        test_back_to_back(400);
        test_full_structures(600);
        s_tvalid <= 1'b0;
        while (pending_issues.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Sent %0d transactions: %0d cycle ends, %0d issued, %0d flushes.",
                 items_sent, n_cycle_ends, n_issued, n_flushes);
        $display("Dispatches dropped on a full station: %0d; table entries ignored: %0d.",
                 n_dropped, n_snap_ignored);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
